// ===== hdl/websocket_accept_key_sha1_top_macros.svh =====
// Assertion helpers used by wak_back
`ifndef WEBSOCKET_ACCEPT_KEY_SHA1_TOP_MACROS_SVH
`define WEBSOCKET_ACCEPT_KEY_SHA1_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define WAK_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define WAK_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define WAK_ASSERT_IMP(label, clk, rst, a, c)
`define WAK_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// ===== hdl/wak_pkg.sv =====
package wak_pkg;

  localparam int unsigned GUID_LEN = 36;
  localparam int unsigned CHAR_CNT = 28;

  // queue entry from front to back: a message byte and its end mark
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } wak_word_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_GUID  = 7'b0000010,
    ST_PAD   = 7'b0000100,
    ST_LEN   = 7'b0001000,
    ST_ROUND = 7'b0010000,
    ST_FOLD  = 7'b0100000,
    ST_OUT   = 7'b1000000
  } wak_state_t;

  function automatic logic [7:0] guid_byte(input logic [5:0] idx);
    logic [8*GUID_LEN-1:0] s;
    s = "258EAFA5-E914-47DA-95CA-C5AB0DC85B11";
    return s[8*(GUID_LEN-1-idx) +: 8];
  endfunction

  function automatic logic [6:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) c = 8'd65 + {2'b00, v};
    else if (v < 6'd52) c = 8'd71 + {2'b00, v};
    else if (v < 6'd62) c = {2'b00, v} - 8'd4;
    else if (v == 6'd62) c = 8'd43;
    else c = 8'd47;
    return c[6:0];
  endfunction

  function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

endpackage

// ===== hdl/wak_front.sv =====
// Accept key bytes and push them into a two-entry queue.
module wak_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data,
  input  logic                in_last,
  output logic                q_valid,
  input  logic                q_ready,
  output wak_pkg::wak_word_t  q_word
);
  wak_pkg::wak_word_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_word   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mem[wr_ptr] <= '{data: in_data, last: in_last};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) wr_ptr <= ~wr_ptr;
      if (q_valid && q_ready) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, in_valid && in_ready} - {1'b0, q_valid && q_ready};
    end
  end
endmodule

// ===== hdl/wak_back.sv =====
`include "websocket_accept_key_sha1_top_macros.svh"
// Hash engine: buffer the block, run one round a cycle, then emit base64.
module wak_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  wak_pkg::wak_word_t  q_word,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [6:0]          out_char,
  output logic                out_last
);
  wak_pkg::wak_state_t state;
  wak_pkg::wak_state_t resume;
  logic [31:0] w [16];
  logic [31:0] h [5];
  logic [31:0] a, b, c, d, e;
  logic [5:0]  fill;
  logic [63:0] total;
  logic [6:0]  rnd;
  logic [5:0]  idx;
  logic        final_blk;
  logic [167:0] dig;
  logic [4:0]  ocnt;

  logic        take;
  logic [7:0]  in_b;
  logic        ab;
  logic [31:0] f, k, t, wn, wcur;

  assign q_ready = (state == wak_pkg::ST_IDLE);

  always_comb begin
    ab   = 1'b0;
    in_b = 8'h00;
    unique case (state)
      wak_pkg::ST_IDLE: begin ab = q_valid; in_b = q_word.data; end
      wak_pkg::ST_GUID: begin ab = 1'b1; in_b = wak_pkg::guid_byte(idx); end
      wak_pkg::ST_PAD:  begin ab = 1'b1; in_b = (idx == 6'd0) ? 8'h80 : 8'h00; end
      wak_pkg::ST_LEN:  begin
        ab = 1'b1;
        in_b = 8'(({total[60:0], 3'b000}) >> (8 * (7 - idx[2:0])));
      end
      default: begin ab = 1'b0; in_b = 8'h00; end
    endcase
    take = ab && (fill == 6'd63);
  end

  always_comb begin
    wcur = w[0];
    wn   = wak_pkg::rol(w[13] ^ w[8] ^ w[2] ^ w[0], 1);
    if (rnd < 7'd20) begin f = (b & c) | (~b & d); k = 32'h5A827999; end
    else if (rnd < 7'd40) begin f = b ^ c ^ d; k = 32'h6ED9EBA1; end
    else if (rnd < 7'd60) begin f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC; end
    else begin f = b ^ c ^ d; k = 32'hCA62C1D6; end
    t = wak_pkg::rol(a, 5) + f + e + k + wcur;
  end

  assign out_valid = (state == wak_pkg::ST_OUT);
  assign out_char  = (ocnt == 5'd27) ? 7'd61 : wak_pkg::b64_char(dig[167:162]);
  assign out_last  = (ocnt == 5'd27);

  always_ff @(posedge clk) begin
    if (ab) begin
      w[fill[5:2]][8*(3-fill[1:0]) +: 8] <= in_b;
    end else if (state == wak_pkg::ST_ROUND) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wn;
    end
    if (state == wak_pkg::ST_ROUND) begin
      a <= t; b <= a; c <= wak_pkg::rol(b, 30); d <= c; e <= d;
    end else begin
      a <= h[0]; b <= h[1]; c <= h[2]; d <= h[3]; e <= h[4];
    end
    if (state == wak_pkg::ST_FOLD) begin
      dig <= {h[0] + a, h[1] + b, h[2] + c, h[3] + d, h[4] + e, 8'h00};
    end else if (out_valid && out_ready) begin
      dig <= {dig[161:0], 6'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wak_pkg::ST_IDLE;
      resume <= wak_pkg::ST_IDLE;
      h <= '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0};
      fill <= 6'd0; total <= 64'd0; rnd <= 7'd0; idx <= 6'd0;
      final_blk <= 1'b0; ocnt <= 5'd0;
    end else begin
      if (ab) fill <= fill + 6'd1;
      if (ab && (state == wak_pkg::ST_IDLE || state == wak_pkg::ST_GUID))
        total <= total + 64'd1;
      unique case (state)
        wak_pkg::ST_IDLE: begin
          idx <= 6'd0;
          if (take) begin
            state <= wak_pkg::ST_ROUND; rnd <= 7'd0;
            final_blk <= 1'b0;
            // resume into GUID after block if this was the last key byte, else into IDLE
            if (q_word.last) resume <= wak_pkg::ST_GUID;
            else resume <= wak_pkg::ST_IDLE;
          end else if (q_valid && q_word.last) state <= wak_pkg::ST_GUID;
        end
        wak_pkg::ST_GUID: begin
          idx <= idx + 6'd1;
          if (idx == 6'(wak_pkg::GUID_LEN - 1)) begin
            idx <= 6'd0;
            if (take) begin
              state <= wak_pkg::ST_ROUND; rnd <= 7'd0; resume <= wak_pkg::ST_PAD;
            end else state <= wak_pkg::ST_PAD;
          end else if (take) begin
            state <= wak_pkg::ST_ROUND; rnd <= 7'd0; resume <= wak_pkg::ST_GUID;
          end
        end
        wak_pkg::ST_PAD: begin
          idx <= idx + 6'd1;
          if (take) begin
            state <= wak_pkg::ST_ROUND; rnd <= 7'd0; resume <= wak_pkg::ST_PAD;
          end
          else if (fill == 6'd55) begin state <= wak_pkg::ST_LEN; idx <= 6'd0; end
        end
        wak_pkg::ST_LEN: begin
          idx <= idx + 6'd1;
          if (take) begin state <= wak_pkg::ST_ROUND; rnd <= 7'd0; final_blk <= 1'b1; end
        end
        wak_pkg::ST_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == 7'd79) state <= wak_pkg::ST_FOLD;
        end
        wak_pkg::ST_FOLD: begin
          h[0] <= h[0] + a; h[1] <= h[1] + b; h[2] <= h[2] + c;
          h[3] <= h[3] + d; h[4] <= h[4] + e;
          if (final_blk) begin
            state <= wak_pkg::ST_OUT; ocnt <= 5'd0;
          end else begin
            state <= resume;
          end
        end
        wak_pkg::ST_OUT: begin
          if (out_ready) begin
            ocnt <= ocnt + 5'd1;
            if (ocnt == 5'd27) begin
              state <= wak_pkg::ST_IDLE;
              h <= '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476,
                     32'hC3D2E1F0};
              fill <= 6'd0; total <= 64'd0; final_blk <= 1'b0;
            end
          end
        end
        default: state <= wak_pkg::ST_IDLE;
      endcase
    end
  end

  `WAK_ASSERT_IMP(a_out_idle, clk, rst, out_valid, !q_ready)
  `WAK_ASSERT_NXT(a_rnd_fold, clk, rst,
    (state == wak_pkg::ST_ROUND) && (rnd == 7'd79), state == wak_pkg::ST_FOLD)
  `WAK_ASSERT_IMP(a_last_eq, clk, rst, out_valid && out_last, out_char == 7'd61)
endmodule

// ===== hdl/websocket_accept_key_sha1_top.sv =====
// Flow: a non-final key byte fills the block buffer; a full block is compressed
// (80 rounds plus a fold) before more bytes are taken. Final byte: GUID and padding
// at one byte a cycle between blocks, then 28 characters at one per ready cycle.
// Throughput: one key at a time; a new key starts after the last character.
// Reset (rst, synchronous): chaining words, fill count and byte total return
// to the SHA-1 initial state; the queue empties.
module websocket_accept_key_sha1_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] key_byte
  input  logic       s_axis_tlast,   // key_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [6:0] accept_char, [7] zero
  output logic       m_axis_tlast    // accept_last
);
  logic               q_valid;
  logic               q_ready;
  wak_pkg::wak_word_t q_word;
  logic [6:0]         ch;

  wak_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_data(s_axis_tdata), .in_last(s_axis_tlast),
    .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word)
  );

  wak_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_word(q_word),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_char(ch), .out_last(m_axis_tlast)
  );

  assign m_axis_tdata = {1'b0, ch};
endmodule

// ===== tb/tb_websocket_accept_key_sha1_top.sv =====
`timescale 1ns / 100ps

module tb_websocket_accept_key_sha1_top;

  logic       clk;
  logic       rst;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [7:0] key_byte
  logic       s_axis_tlast;   // key_last
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [6:0] accept_char, [7] zero
  logic       m_axis_tlast;   // accept_last

  websocket_accept_key_sha1_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } accept_word_t;

  typedef struct {
    logic [7:0] key;
    logic       last;
    bit         typed;     // expected accept string given in the row
    string      accept;
  } key_row_t;

  localparam string GUID_STR = "258EAFA5-E914-47DA-95CA-C5AB0DC85B11";
  localparam string B64_STR =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  // predictor state
  logic [31:0] hash_h [5];
  logic [7:0]  blk_buf [64];
  int unsigned blk_fill;
  logic [63:0] msg_bytes;

  accept_word_t accept_q[$];
  int          mismatches;
  bit          quiet_out;
  int          sent_keys;

  function automatic logic [31:0] rotl(logic [31:0] x, int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  task automatic hash_init();
    hash_h[0] = 32'h67452301; hash_h[1] = 32'hEFCDAB89; hash_h[2] = 32'h98BADCFE;
    hash_h[3] = 32'h10325476; hash_h[4] = 32'hC3D2E1F0;
    blk_fill = 0;
    msg_bytes = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
    for (int i = 16; i < 80; i++)
      w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
    a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3]; e = hash_h[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d); k = 32'h5A827999;
      end else if (i < 40) begin
        f = b ^ c ^ d; k = 32'h6ED9EBA1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; k = 32'hCA62C1D6;
      end
      t = rotl(a, 5) + f + e + k + w[i];
      e = d; d = c; c = rotl(b, 30); b = a; a = t;
    end
    hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d; hash_h[4] += e;
  endtask

  task automatic push_byte(logic [7:0] v, bit counted);
    if (counted) msg_bytes += 1;
    blk_buf[blk_fill] = v;
    blk_fill = (blk_fill + 1) % 64;
    if (blk_fill == 0) compress_block();
  endtask

  // absorb one key word; on the final word queue the 28 accept characters
  task automatic predict_accept(logic [7:0] key, logic last);
    logic [7:0]  dig [21];
    logic [63:0] bit_len;
    logic [23:0] v;
    int o;
    push_byte(key, 1);
    if (!last) return;
    for (int i = 0; i < 36; i++) push_byte(GUID_STR[i], 1);
    bit_len = msg_bytes << 3;
    push_byte(8'h80, 0);
    while (blk_fill != 56) push_byte(8'h00, 0);
    for (int i = 0; i < 8; i++) push_byte(bit_len[56 - 8*i +: 8], 0);
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 4; j++) dig[4*i+j] = hash_h[i][24 - 8*j +: 8];
    dig[20] = 8'h00;
    o = 0;
    for (int i = 0; i < 21; i += 3) begin
      v = {dig[i], dig[i+1], dig[i+2]};
      accept_q.push_back('{B64_STR[v[23:18]], 1'b0});
      accept_q.push_back('{B64_STR[v[17:12]], 1'b0});
      accept_q.push_back('{B64_STR[v[11:6]], 1'b0});
      accept_q.push_back('{(i + 3 < 21) ? B64_STR[v[5:0]] : "=", o == 6});
      o++;
    end
    hash_init();
  endtask

  task automatic report_miss(string what, accept_word_t exp_w, accept_word_t got_w);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected ch=%02h last=%0b, got ch=%02h last=%0b",
               what, exp_w.ch, exp_w.last, got_w.ch, got_w.last);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("status: fail");
    $finish;
  end

  // output side: random stalls, with a quiet stretch
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= quiet_out || ($urandom_range(99) >= 29);
  end

  always @(posedge clk) begin
    accept_word_t got_w, exp_w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_w = '{m_axis_tdata, m_axis_tlast};
      if (accept_q.size() == 0) begin
        report_miss("unexpected", '0, got_w);
      end else begin
        exp_w = accept_q.pop_front();
        if (got_w !== exp_w) report_miss("data", exp_w, got_w);
      end
    end
  end

  // present one word, random idle before it unless quiet; hold until taken
  task automatic send_key_word(logic [7:0] key, logic last, bit quiet);
    while (!quiet && $urandom_range(99) < 29) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= key;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_accept(key, last);
    sent_keys++;
  endtask

  task automatic send_random_key(int len, bit quiet);
    for (int i = 0; i < len; i++)
      send_key_word($urandom_range(255), i == len - 1, quiet);
  endtask

  key_row_t rows[$];
  int wait_cnt;

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    quiet_out = 1'b0;
    mismatches = 0;
    sent_keys = 0;
    hash_init();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: standard handshake sample key, one-byte keys, zero bytes, extremes
    begin
      string sample;
      sample = "dGhlIHNhbXBsZSBub25jZQ==";
      for (int i = 0; i < sample.len(); i++)
        rows.push_back('{sample[i], i == sample.len() - 1, i == sample.len() - 1,
                         "s3pPLMBiTxaQ9kYGzzhZRbK+xOo="});
    end
    rows.push_back('{8'h00, 1'b1, 1'b0, ""});
    rows.push_back('{8'hFF, 1'b1, 1'b0, ""});
    rows.push_back('{8'h00, 1'b0, 1'b0, ""});
    rows.push_back('{8'hFF, 1'b0, 1'b0, ""});
    rows.push_back('{8'hAA, 1'b0, 1'b0, ""});
    rows.push_back('{8'h55, 1'b1, 1'b0, ""});
    foreach (rows[r]) begin
      send_key_word(rows[r].key, rows[r].last, 1'b0);
      if (rows[r].typed) begin
        // typed accept string must match what the predictor queued
        for (int i = 0; i < 28; i++)
          if (accept_q[accept_q.size() - 28 + i].ch != rows[r].accept[i])
            report_miss("table", '{rows[r].accept[i], i == 27},
                        accept_q[accept_q.size() - 28 + i]);
      end
    end

    // random keys: mostly short, a few spanning several blocks
    while (sent_keys < 350) begin
      int len;
      bit quiet;
      quiet = (sent_keys > 200 && sent_keys < 260);
      quiet_out = quiet;
      if ($urandom_range(9) == 0) len = $urandom_range(60, 140);
      else len = $urandom_range(1, 30);
      send_random_key(len, quiet);
    end
    s_axis_tvalid <= 1'b0;
    quiet_out = 1'b0;

    wait_cnt = 0;
    while (accept_q.size() != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (300) @(posedge clk);
    if (mismatches == 0 && accept_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
